// ----- rtl/dwptr_pkg.sv -----
// Shared types, constants and helpers for the DWARF encoded pointer decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dwptr_pkg;

    // Width of a target pointer in bytes (valid range 2..8)
    localparam int POINTER_BYTES = 4;

    // Result is truncated to pointer width, then to the 32-bit output
    localparam logic [31:0] PTR_MASK = (POINTER_BYTES >= 4) ? 32'hFFFF_FFFF :
        32'((64'd1 << (8 * POINTER_BYTES)) - 64'd1);

    // Encoding byte fields
    localparam logic [7:0] ENC_OMIT = 8'hFF;
    localparam logic [2:0] REL_ABS  = 3'd0;
    localparam logic [2:0] REL_PC   = 3'd1;

    // Value formats (low nibble of the encoding)
    localparam logic [3:0] FMT_ABSPTR = 4'h0;
    localparam logic [3:0] FMT_ULEB   = 4'h1;
    localparam logic [3:0] FMT_UDATA2 = 4'h2;
    localparam logic [3:0] FMT_UDATA4 = 4'h3;
    localparam logic [3:0] FMT_UDATA8 = 4'h4;
    localparam logic [3:0] FMT_SLEB   = 4'h9;
    localparam logic [3:0] FMT_SDATA2 = 4'hA;
    localparam logic [3:0] FMT_SDATA4 = 4'hB;
    localparam logic [3:0] FMT_SDATA8 = 4'hC;

    // LEB shift limit: bits at or above this are dropped
    localparam logic [6:0] LEB_LIMIT = 7'd64;
    localparam logic [6:0] LEB_STEP  = 7'd7;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_FORMAT   = 2'd1,
        ERR_RELATIVE = 2'd2
    } err_t;

    // Decoder state carried between items. Only the low 32 bits of the
    // accumulator can reach the output, so only those are kept.
    typedef struct packed {
        logic        active;
        logic [31:0] acc;
        logic [6:0]  cnt;
        logic [7:0]  enc;
        logic [31:0] base;
    } dec_state_t;

    // One result item plus its emit flag
    typedef struct packed {
        logic        emit;
        logic [31:0] value;
        logic        used;
        logic        indirect;
        err_t        err;
    } dec_result_t;

    // Supported value format?
    function automatic logic fmt_ok(input logic [3:0] fmt);
        logic ok;
        begin
            case (fmt)
                FMT_ABSPTR, FMT_ULEB, FMT_UDATA2, FMT_UDATA4, FMT_UDATA8,
                FMT_SLEB, FMT_SDATA2, FMT_SDATA4, FMT_SDATA8: ok = 1'b1;
                default: ok = 1'b0;
            endcase
            return ok;
        end
    endfunction

    // Byte length of a fixed-width format; 0 for LEB128 and unsupported
    function automatic logic [3:0] fmt_size(input logic [3:0] fmt);
        logic [3:0] sz;
        begin
            case (fmt)
                FMT_ABSPTR:             sz = 4'(POINTER_BYTES);
                FMT_UDATA2, FMT_SDATA2: sz = 4'd2;
                FMT_UDATA4, FMT_SDATA4: sz = 4'd4;
                FMT_UDATA8, FMT_SDATA8: sz = 4'd8;
                default:                sz = 4'd0;
            endcase
            return sz;
        end
    endfunction

endpackage

// ----- rtl/dwarf_encoded_pointer_decoder_unit.sv -----
// Top level of the DWARF encoded pointer decoder: input register, state,
// result register and config register. Depends on dwptr_pkg, dwptr_core.
`timescale 1ns / 1ps
//
//  channel  | ports                                            | direction
//  ---------+--------------------------------------------------+----------
//  input    | s_valid s_ready s_data_byte s_first_byte         | in
//           | s_encoding s_start_address                       |
//  result   | m_valid m_ready m_value m_byte_used              | out
//           | m_needs_indirect m_error_code                    |
//  config   | cfg_we cfg_wdata (big_endian)                    | in
//
//  One byte is accepted per cycle while the input register can drain; a result
//  goes out of the result register once the byte that completes its value has passed the input register.
//  The decode loop through the state register sets the rate.
//  Synchronous active-low reset clears the decoder to idle and big_endian to 0.
//  A stalled result holds the output; bytes keep entering while the
//  input register can still drain into a free or draining result register.

module dwarf_encoded_pointer_decoder_unit import dwptr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // config
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    input  logic [7:0]  s_encoding,
    input  logic [31:0] s_start_address,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value,
    output logic        m_byte_used,
    output logic        m_needs_indirect,
    output logic [1:0]  m_error_code
);

    logic        big_endian_reg;
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg;
    logic [7:0]  in_enc_reg;
    logic [31:0] in_addr_reg;
    dec_state_t  state_reg, state_next;
    dec_result_t res;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_value_reg;
    logic        out_used_reg;
    logic        out_ind_reg;
    err_t        out_err_reg;
    logic        out_free;
    logic        advance;

    // Handshake: the input register drains whenever the result register can take
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    dwptr_core u_core (
        .st            (state_reg),
        .big_endian    (big_endian_reg),
        .data_byte     (in_byte_reg),
        .first_byte    (in_first_reg),
        .encoding      (in_enc_reg),
        .start_address (in_addr_reg),
        .st_next       (state_next),
        .res           (res)
    );

    // Valid flags
    always_comb begin
        in_valid_next = s_ready ? s_valid : in_valid_reg;
        if (advance && res.emit)
            out_valid_next = 1'b1;
        else if (m_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            big_endian_reg <= 1'b0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end else begin
            if (cfg_we)
                big_endian_reg <= cfg_wdata;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_data_byte;
            in_first_reg <= s_first_byte;
            in_enc_reg   <= s_encoding;
            in_addr_reg  <= s_start_address;
        end
        if (advance && res.emit) begin
            out_value_reg <= res.value;
            out_used_reg  <= res.used;
            out_ind_reg   <= res.indirect;
            out_err_reg   <= res.err;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_value          = out_value_reg;
    assign m_byte_used      = out_used_reg;
    assign m_needs_indirect = out_ind_reg;
    assign m_error_code     = out_err_reg;

endmodule

// ----- rtl/dwptr_core.sv -----
// Per-byte decode step: next decoder state and the result item for one byte.
// Depends on dwptr_pkg. Purely combinational.
`timescale 1ns / 1ps

module dwptr_core import dwptr_pkg::*; (
    input  dec_state_t  st,
    input  logic        big_endian,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic [7:0]  encoding,
    input  logic [31:0] start_address,
    output dec_state_t  st_next,
    output dec_result_t res
);

    always_comb begin
        logic        omit;
        logic        bad_fmt;
        logic        bad_rel;
        logic        proceed;
        logic        is_leb;
        logic        done;
        logic [3:0]  fmt;
        logic [3:0]  size;
        dec_state_t  cur;
        logic [31:0] acc_leb;
        logic [6:0]  cnt_leb;
        logic [31:0] acc_fix;
        logic [6:0]  cnt_fix;
        logic [31:0] val;

        // New-value checks on the incoming encoding byte
        omit    = first_byte && (encoding == ENC_OMIT);
        bad_fmt = first_byte && !omit && !fmt_ok(encoding[3:0]);
        bad_rel = first_byte && !omit && !bad_fmt &&
                  (encoding[6:4] != REL_ABS) && (encoding[6:4] != REL_PC);

        // A first byte starts from fresh state
        cur = st;
        if (first_byte) begin
            cur.active = 1'b1;
            cur.enc    = encoding;
            cur.base   = start_address;
            cur.acc    = '0;
            cur.cnt    = '0;
        end
        proceed = first_byte ? !(omit || bad_fmt || bad_rel) : st.active;

        fmt    = cur.enc[3:0];
        size   = fmt_size(fmt);
        is_leb = (fmt == FMT_ULEB) || (fmt == FMT_SLEB);

        // LEB128: 7 payload bits per byte, shift saturates past 63
        acc_leb = cur.acc;
        if (cur.cnt < 7'd32)
            acc_leb = acc_leb | ({25'd0, data_byte[6:0]} << cur.cnt[4:0]);
        cnt_leb = (cur.cnt < LEB_LIMIT) ? cur.cnt + LEB_STEP : cur.cnt;
        if ((fmt == FMT_SLEB) && !data_byte[7] && data_byte[6] && (cnt_leb < 7'd32))
            acc_leb = acc_leb | (32'hFFFF_FFFF << cnt_leb[4:0]);

        // Fixed width: shift in (big-endian) or place by byte index
        if (big_endian)
            acc_fix = {cur.acc[23:0], data_byte};
        else if (!cur.cnt[2])
            acc_fix = cur.acc | ({24'd0, data_byte} << {cur.cnt[1:0], 3'b000});
        else
            acc_fix = cur.acc;
        cnt_fix = cur.cnt + 7'd1;

        done = is_leb ? !data_byte[7] : (cnt_fix >= {3'd0, size});

        // Finish: sign extend 16-bit data, add base for pc-relative
        val = is_leb ? acc_leb : acc_fix;
        if ((fmt == FMT_SDATA2) && val[15])
            val[31:16] = 16'hFFFF;
        if (cur.enc[6:4] == REL_PC)
            val = val + cur.base;
        val = val & PTR_MASK;

        // Next state
        st_next = st;
        if (proceed) begin
            st_next        = cur;
            st_next.acc    = is_leb ? acc_leb : acc_fix;
            st_next.cnt    = is_leb ? cnt_leb : cnt_fix;
            st_next.active = !done;
        end else if (first_byte) begin
            st_next.active = 1'b0;
        end

        // Result item
        res.emit     = 1'b0;
        res.value    = '0;
        res.used     = 1'b1;
        res.indirect = 1'b0;
        res.err      = ERR_OK;
        if (omit) begin
            res.emit = 1'b1;
            res.used = 1'b0;
        end else if (bad_fmt) begin
            res.emit = 1'b1;
            res.err  = ERR_FORMAT;
        end else if (bad_rel) begin
            res.emit = 1'b1;
            res.err  = ERR_RELATIVE;
        end else if (proceed && done) begin
            res.emit     = 1'b1;
            res.value    = val;
            res.indirect = cur.enc[7];
        end
    end

endmodule

// ----- rtl/dwptr_checker.sv -----
// Port-level checks for the DWARF encoded pointer decoder, bound to the top.
// Depends on dwptr_pkg and dwarf_encoded_pointer_decoder_unit.
`timescale 1ns / 1ps

module dwptr_checker import dwptr_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_value,
    input logic        m_byte_used,
    input logic        m_needs_indirect,
    input logic [1:0]  m_error_code
);

    // No result item survives reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result item holds its valid, value and error code
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_error_code))
        else $error("stalled result changed");

    // Omit: nothing consumed, zero value, no error
    a_omit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_used |->
            m_value == 32'd0 && !m_needs_indirect && m_error_code == ERR_OK)
        else $error("bad omit result");

    // Errors consume the byte and give zero
    a_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_code != ERR_OK |->
            m_byte_used && m_value == 32'd0 && !m_needs_indirect &&
            (m_error_code == ERR_FORMAT || m_error_code == ERR_RELATIVE))
        else $error("bad error result");

endmodule

bind dwarf_encoded_pointer_decoder_unit dwptr_checker u_dwptr_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_value          (m_value),
    .m_byte_used      (m_byte_used),
    .m_needs_indirect (m_needs_indirect),
    .m_error_code     (m_error_code)
);

// ----- sim/dwptr_result_checker.sv -----
// Result checker for the DWARF encoded pointer decoder: watches the config port and
// both channels, predicts each decoded pointer and compares it with what comes out.
// Depends on dwptr_pkg for the pointer width, format codes and error codes.
`timescale 1ns / 1ps

module dwptr_result_checker import dwptr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    input  logic [7:0]  s_encoding,
    input  logic [31:0] s_start_address,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_value,
    input  logic        m_byte_used,
    input  logic        m_needs_indirect,
    input  logic [1:0]  m_error_code,
    output int          mismatches,
    output int          pending
);

    // Pointer-width truncation applied before the 32-bit output
    localparam logic [63:0] PTR_WIDTH_MASK = (POINTER_BYTES >= 8) ? ~64'd0 :
        ((64'd1 << (8 * POINTER_BYTES)) - 64'd1);

    typedef struct packed {
        logic [31:0] value;
        logic        used;
        logic        indirect;
        err_t        err;
    } ptr_result_t;

    ptr_result_t expected_ptrs[$];
    ptr_result_t want;

    // Decoder copy: byte order, accumulator and the held encoding
    logic        big_endian;
    logic [63:0] acc;
    logic [6:0]  shift;
    logic [7:0]  held_enc;
    logic [31:0] held_base;
    logic        busy;

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    // Byte count of a fixed-width format; 0 for LEB128, -1 if unsupported
    function automatic int value_length(input logic [3:0] fmt);
        int len;
        case (fmt)
            FMT_ABSPTR:             len = POINTER_BYTES;
            FMT_ULEB, FMT_SLEB:     len = 0;
            FMT_UDATA2, FMT_SDATA2: len = 2;
            FMT_UDATA4, FMT_SDATA4: len = 4;
            FMT_UDATA8, FMT_SDATA8: len = 8;
            default:                len = -1;
        endcase
        return len;
    endfunction

    task automatic push_result(input logic [31:0] v, input logic used, input logic ind,
                               input err_t e);
        ptr_result_t r;
        r.value    = v;
        r.used     = used;
        r.indirect = ind;
        r.err      = e;
        expected_ptrs.push_back(r);
    endtask

    // Sign fill for sdata2/sdata4, pc-relative base, then truncate
    task automatic complete_value();
        logic [63:0] v;
        v = acc;
        if (held_enc[3:0] == FMT_SDATA2 && v[15])
            v[63:16] = '1;
        if (held_enc[3:0] == FMT_SDATA4 && v[31])
            v[63:32] = '1;
        if (held_enc[6:4] == REL_PC)
            v = v + {32'd0, held_base};
        v = v & PTR_WIDTH_MASK;
        push_result(v[31:0], 1'b1, held_enc[7], ERR_OK);
        busy = 1'b0;
    endtask

    // One accepted byte through the decoder copy
    task automatic decode_byte(input logic [7:0] b, input logic first, input logic [7:0] enc,
                               input logic [31:0] addr);
        int len;
        if (first) begin
            busy = 1'b0;
            if (enc == ENC_OMIT) begin
                push_result(32'd0, 1'b0, 1'b0, ERR_OK);
                return;
            end
            if (value_length(enc[3:0]) < 0) begin
                push_result(32'd0, 1'b1, 1'b0, ERR_FORMAT);
                return;
            end
            if (enc[6:4] != REL_ABS && enc[6:4] != REL_PC) begin
                push_result(32'd0, 1'b1, 1'b0, ERR_RELATIVE);
                return;
            end
            held_enc  = enc;
            held_base = addr;
            acc       = 64'd0;
            shift     = 7'd0;
            busy      = 1'b1;
        end else if (!busy) begin
            // stray byte while idle
            return;
        end

        len = value_length(held_enc[3:0]);
        if (len == 0) begin
            // LEB128: bits past 64 dropped, shift stops growing at 70
            if (shift < LEB_LIMIT) begin
                acc   = acc | ({57'd0, b[6:0]} << shift);
                shift = shift + LEB_STEP;
            end
            if (b[7])
                return;
            if (held_enc[3:0] == FMT_SLEB && b[6] && shift < LEB_LIMIT)
                acc = acc | (~64'd0 << shift);
            complete_value();
        end else begin
            if (big_endian)
                acc = {acc[55:0], b};
            else
                acc = acc | ({56'd0, b} << (8 * shift[2:0]));
            shift = shift + 7'd1;
            if (shift >= len)
                complete_value();
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            big_endian = 1'b0;
            acc        = 64'd0;
            shift      = 7'd0;
            held_enc   = 8'd0;
            held_base  = 32'd0;
            busy       = 1'b0;
            expected_ptrs.delete();
        end else begin
            // Outgoing result against the oldest expectation
            if (m_valid && m_ready) begin
                if (expected_ptrs.size() == 0) begin
                    $error("unexpected result item: value %h", m_value);
                    mismatches++;
                end else begin
                    want = expected_ptrs.pop_front();
                    if (m_value !== want.value) begin
                        $error("value: expected %h, got %h", want.value, m_value);
                        mismatches++;
                    end
                    if (m_byte_used !== want.used) begin
                        $error("byte_used: expected %b, got %b", want.used, m_byte_used);
                        mismatches++;
                    end
                    if (m_needs_indirect !== want.indirect) begin
                        $error("needs_indirect: expected %b, got %b",
                               want.indirect, m_needs_indirect);
                        mismatches++;
                    end
                    if (m_error_code !== want.err) begin
                        $error("error_code: expected %0d, got %0d", want.err, m_error_code);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
                big_endian = cfg_wdata;
            if (s_valid && s_ready)
                decode_byte(s_data_byte, s_first_byte, s_encoding, s_start_address);
        end
        pending = expected_ptrs.size();
    end

endmodule

// ----- sim/dwarf_encoded_pointer_decoder_unit_tb.sv -----
// Testbench top for dwarf_encoded_pointer_decoder_unit: clock, reset, byte stream and
// config stimulus, random backpressure and the verdict. Depends on dwptr_pkg, the
// decoder RTL and dwptr_result_checker.
`timescale 1ns / 1ps

module dwarf_encoded_pointer_decoder_unit_tb;
    import dwptr_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int ITEM_TARGET  = 1300;
    localparam int PHASE_ITEMS  = 160;
    localparam int IDLE_PCT     = 9;
    localparam int DRAIN_CYCLES = 6;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        cfg_we          = 1'b0;
    logic        cfg_wdata       = 1'b0;
    logic        s_valid         = 1'b0;
    logic [7:0]  s_data_byte     = 8'd0;
    logic        s_first_byte    = 1'b0;
    logic [7:0]  s_encoding      = 8'd0;
    logic [31:0] s_start_address = 32'd0;
    logic        m_ready         = 1'b1;
    logic        s_ready;
    logic        m_valid;
    logic [31:0] m_value;
    logic        m_byte_used;
    logic        m_needs_indirect;
    logic [1:0]  m_error_code;

    int mismatches;
    int pending;
    int cycle_count = 0;
    int value_items = 0;
    int phase;
    int phase_end;
    bit gaps_on     = 1'b1;
    bit stalls_on   = 1'b1;

    dwarf_encoded_pointer_decoder_unit DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_first_byte     (s_first_byte),
        .s_encoding       (s_encoding),
        .s_start_address  (s_start_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_value          (m_value),
        .m_byte_used      (m_byte_used),
        .m_needs_indirect (m_needs_indirect),
        .m_error_code     (m_error_code)
    );

    dwptr_result_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_first_byte     (s_first_byte),
        .s_encoding       (s_encoding),
        .s_start_address  (s_start_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_value          (m_value),
        .m_byte_used      (m_byte_used),
        .m_needs_indirect (m_needs_indirect),
        .m_error_code     (m_error_code),
        .mismatches       (mismatches),
        .pending          (pending)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("dwarf_encoded_pointer_decoder_unit_tb failed");
            $finish;
        end
    end

    // Random result backpressure
    always @(posedge aclk) begin
        m_ready <= !stalls_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Present one item, with random gaps before it, and wait for its handshake
    task automatic push_byte(input logic [7:0] b, input logic first, input logic [7:0] enc,
                             input logic [31:0] addr);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_data_byte     <= b;
        s_first_byte    <= first;
        s_encoding      <= enc;
        s_start_address <= addr;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Hold off the sender until every expected result is out, then let the pipe settle
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_byte_order(input logic be);
        cfg_we    <= 1'b1;
        cfg_wdata <= be;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Supported format, absolute or pc-relative, random indirect bit
    function automatic logic [7:0] well_formed_encoding();
        logic [3:0] fmt;
        logic [2:0] rel;
        case ($urandom_range(0, 8))
            0:       fmt = FMT_ABSPTR;
            1:       fmt = FMT_ULEB;
            2:       fmt = FMT_UDATA2;
            3:       fmt = FMT_UDATA4;
            4:       fmt = FMT_UDATA8;
            5:       fmt = FMT_SLEB;
            6:       fmt = FMT_SDATA2;
            7:       fmt = FMT_SDATA4;
            default: fmt = FMT_SDATA8;
        endcase
        rel = $urandom_range(0, 1) ? REL_PC : REL_ABS;
        return {1'($urandom_range(0, 1)), rel, fmt};
    endfunction

    // Whole encoded value with random content; cut stops it early
    task automatic send_value(input logic [7:0] enc, input int cut);
        int          len;
        bit          leb;
        logic [7:0]  b;
        logic [31:0] addr;
        len  = int'(fmt_size(enc[3:0]));
        leb  = (len == 0);
        if (leb)
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
        addr = $urandom;
        if ($urandom_range(0, 9) == 0)
            addr = {32{addr[0]}};
        for (int i = 0; i < len && i < cut; i++) begin
            b = 8'($urandom);
            if ($urandom_range(0, 9) == 0)
                b = {8{b[0]}};
            if (leb)
                b[7] = (i != len - 1);
            push_byte(b, i == 0, (i == 0) ? enc : 8'($urandom), (i == 0) ? addr : $urandom);
            value_items++;
        end
    endtask

    // Mostly well-formed values, some noise, omits and cut-off values
    task automatic random_item();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 78) begin
            send_value(well_formed_encoding(), 99);
        end else if (kind < 84) begin
            push_byte(8'($urandom), 1'b1, 8'($urandom), $urandom);
            value_items++;
        end else if (kind < 89) begin
            push_byte(8'($urandom), 1'b1, ENC_OMIT, $urandom);
            value_items++;
        end else if (kind < 94) begin
            push_byte(8'($urandom), 1'b0, 8'($urandom), $urandom);
        end else begin
            send_value(well_formed_encoding(), $urandom_range(1, 3));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        write_byte_order(1'b0);

        // Omit, stray byte, bad formats and bad relative modes
        push_byte(8'h00, 1'b1, ENC_OMIT, 32'hFFFF_FFFF);
        push_byte(8'hFF, 1'b0, 8'h00, 32'h0000_0000);
        push_byte(8'h12, 1'b1, 8'h05, 32'h0000_1000);
        push_byte(8'h34, 1'b1, 8'h8F, 32'h0000_1000);
        push_byte(8'h56, 1'b1, 8'h20, 32'h0000_1000);
        push_byte(8'h78, 1'b1, 8'h71, 32'h0000_1000);
        // Absolute pointer, little-endian
        push_byte(8'h78, 1'b1, {1'b0, REL_ABS, FMT_ABSPTR}, 32'h0000_0000);
        push_byte(8'h56, 1'b0, 8'h00, 32'h0000_0000);
        push_byte(8'h34, 1'b0, 8'h00, 32'h0000_0000);
        push_byte(8'h12, 1'b0, 8'h00, 32'h0000_0000);
        // pc-relative udata2 that wraps past the pointer width
        push_byte(8'hFF, 1'b1, {1'b0, REL_PC, FMT_UDATA2}, 32'hFFFF_FFFF);
        push_byte(8'hFF, 1'b0, 8'hFF, 32'hFFFF_FFFF);
        // Negative sdata2, indirect
        push_byte(8'h00, 1'b1, {1'b1, REL_ABS, FMT_SDATA2}, 32'h0000_0000);
        push_byte(8'h80, 1'b0, 8'h00, 32'h0000_0000);
        // ULEB128 three bytes, SLEB128 minus one
        push_byte(8'hE5, 1'b1, {1'b0, REL_ABS, FMT_ULEB}, 32'h0000_0000);
        push_byte(8'h8E, 1'b0, 8'h00, 32'h0000_0000);
        push_byte(8'h26, 1'b0, 8'h00, 32'h0000_0000);
        push_byte(8'h7F, 1'b1, {1'b0, REL_ABS, FMT_SLEB}, 32'h0000_0000);
        // Value abandoned by an omit, then a stray byte while idle
        push_byte(8'h11, 1'b1, {1'b0, REL_ABS, FMT_UDATA4}, 32'h0000_0000);
        push_byte(8'h22, 1'b0, 8'h00, 32'h0000_0000);
        push_byte(8'h00, 1'b1, ENC_OMIT, 32'h0000_0000);
        push_byte(8'h33, 1'b0, 8'h00, 32'h0000_0000);

        // Big-endian udata4
        wait_for_results();
        write_byte_order(1'b1);
        push_byte(8'h12, 1'b1, {1'b0, REL_ABS, FMT_UDATA4}, 32'h0000_0000);
        push_byte(8'h34, 1'b0, 8'h00, 32'h0000_0000);
        push_byte(8'h56, 1'b0, 8'h00, 32'h0000_0000);
        push_byte(8'h78, 1'b0, 8'h00, 32'h0000_0000);

        // Random phases, each with its own byte order; phase 2 runs without idling
        phase = 0;
        while (value_items < ITEM_TARGET) begin
            wait_for_results();
            write_byte_order((phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 :
                             1'($urandom_range(0, 1)));
            gaps_on   = (phase != 2);
            stalls_on = (phase != 2);
            phase_end = (value_items + PHASE_ITEMS < ITEM_TARGET) ?
                        value_items + PHASE_ITEMS : ITEM_TARGET;
            while (value_items < phase_end)
                random_item();
            phase++;
        end

        wait_for_results();
        if (mismatches == 0 && pending == 0)
            $display("dwarf_encoded_pointer_decoder_unit_tb passed");
        else
            $display("dwarf_encoded_pointer_decoder_unit_tb failed");
        $finish;
    end

endmodule
